### hw/rtl/owm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_pkg: shared types and constants of the 1-Wire bus master
// Payload structs for the channels, command and status codes, bus phases
// and the timing register file.
// ----------------------------------------------------------------------------
package owm_pkg;

    localparam int TICK_COUNTER_BITS_DEF = 10;
    localparam int QUEUE_DEPTH = 2;

    // Fixed recovery times after write slots, in ticks.
    localparam int REC_AFTER_ONE = 58;
    localparam int REC_AFTER_ZERO = 2;

    // Timing register reset values.
    localparam logic [9:0] RST_LOW_RESET = 10'd750;
    localparam logic [7:0] RST_RELEASE_RESET = 8'd15;
    localparam logic [7:0] PRES_WAIT_RESET = 8'd100;
    localparam logic [7:0] PRES_LOW_RESET = 8'd240;
    localparam logic [5:0] WR1_LOW_RESET = 6'd8;
    localparam logic [6:0] WR0_LOW_RESET = 7'd70;
    localparam logic [5:0] RD_LOW_RESET = 6'd10;
    localparam logic [6:0] RD_TAIL_RESET = 7'd45;

    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS = 10;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_RST_LOW     = 4'd0,
        CFG_RST_RELEASE = 4'd1,
        CFG_PRES_WAIT   = 4'd2,
        CFG_PRES_LOW    = 4'd3,
        CFG_WR1_LOW     = 4'd4,
        CFG_WR0_LOW     = 4'd5,
        CFG_RD_LOW      = 4'd6,
        CFG_RD_TAIL     = 4'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_RESET = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_kind_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_PRESENCE = 2'd1,
        ST_PULSE_LONG  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_LOW   = 4'd1,
        PH_RST_REL   = 4'd2,
        PH_PRES_HIGH = 4'd3,
        PH_PRES_LOW  = 4'd4,
        PH_WR_LOW    = 4'd5,
        PH_WR_REC    = 4'd6,
        PH_RD_LOW    = 4'd7,
        PH_RD_SAMPLE = 4'd8,
        PH_RD_TAIL   = 4'd9
    } phase_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] write_data;
        logic       line_level;
    } in_item_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] read_data;
    } out_item_t;

    typedef struct packed {
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CFG_DATA_BITS-1:0]  data;
    } cfg_wr_t;

    // One tick after classification, as it waits in the queue.
    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] write_data;
        logic       line_level;
    } tick_item_t;

    typedef struct packed {
        logic push_ready;
        logic pop_valid;
    } queue_status_t;

    typedef struct packed {
        logic [9:0] rst_low;
        logic [7:0] rst_release;
        logic [7:0] pres_wait;
        logic [7:0] pres_low;
        logic [5:0] wr1_low;
        logic [6:0] wr0_low;
        logic [5:0] rd_low;
        logic [6:0] rd_tail;
    } timing_cfg_t;

endpackage

### hw/rtl/owm_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_chan_if: valid/ready channel
// Generic handshake channel; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface owm_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/owm_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_cfg: timing register file
// Holds the eight bus timing registers; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module owm_cfg (
    input  logic                 clk,
    input  logic                 rst_n,
    owm_chan_if.sink             cfg_ch,
    output owm_pkg::timing_cfg_t timing
);

    owm_pkg::timing_cfg_t timing_reg;
    logic                 wr_en;
    logic [owm_pkg::CFG_DATA_BITS-1:0] wdata;

    assign cfg_ch.ready = 1'b1;
    assign wr_en = cfg_ch.valid;
    assign wdata = cfg_ch.payload.data;
    assign timing = timing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.rst_low     <= owm_pkg::RST_LOW_RESET;
            timing_reg.rst_release <= owm_pkg::RST_RELEASE_RESET;
            timing_reg.pres_wait   <= owm_pkg::PRES_WAIT_RESET;
            timing_reg.pres_low    <= owm_pkg::PRES_LOW_RESET;
            timing_reg.wr1_low     <= owm_pkg::WR1_LOW_RESET;
            timing_reg.wr0_low     <= owm_pkg::WR0_LOW_RESET;
            timing_reg.rd_low      <= owm_pkg::RD_LOW_RESET;
            timing_reg.rd_tail     <= owm_pkg::RD_TAIL_RESET;
        end
        else if (wr_en)
        begin
            unique case (cfg_ch.payload.index)
                owm_pkg::CFG_RST_LOW:     timing_reg.rst_low     <= wdata[9:0];
                owm_pkg::CFG_RST_RELEASE: timing_reg.rst_release <= wdata[7:0];
                owm_pkg::CFG_PRES_WAIT:   timing_reg.pres_wait   <= wdata[7:0];
                owm_pkg::CFG_PRES_LOW:    timing_reg.pres_low    <= wdata[7:0];
                owm_pkg::CFG_WR1_LOW:     timing_reg.wr1_low     <= wdata[5:0];
                owm_pkg::CFG_WR0_LOW:     timing_reg.wr0_low     <= wdata[6:0];
                owm_pkg::CFG_RD_LOW:      timing_reg.rd_low      <= wdata[5:0];
                owm_pkg::CFG_RD_TAIL:     timing_reg.rd_tail     <= wdata[6:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

### hw/rtl/owm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_front: tick intake
// Accepts tick items, decodes the command field and pushes them to the queue.
// ----------------------------------------------------------------------------
module owm_front (
    owm_chan_if.sink              in_ch,
    input  owm_pkg::queue_status_t q_status,
    output logic                  push,
    output owm_pkg::tick_item_t   push_item
);

    assign in_ch.ready = q_status.push_ready;
    assign push = in_ch.valid && q_status.push_ready;

    always_comb
    begin
        push_item.write_data = in_ch.payload.write_data;
        push_item.line_level = in_ch.payload.line_level;
        unique case (in_ch.payload.command)
            owm_pkg::CMD_RESET: push_item.kind = owm_pkg::CMD_RESET;
            owm_pkg::CMD_WRITE: push_item.kind = owm_pkg::CMD_WRITE;
            owm_pkg::CMD_READ:  push_item.kind = owm_pkg::CMD_READ;
            default:            push_item.kind = owm_pkg::CMD_NONE;
        endcase
    end

endmodule

### hw/rtl/owm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_queue: tick queue
// Short FIFO between intake and the bus sequencer.
// ----------------------------------------------------------------------------
module owm_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  owm_pkg::tick_item_t    push_item,
    input  logic                   pop,
    output owm_pkg::tick_item_t    pop_item,
    output owm_pkg::queue_status_t q_status
);

    localparam int DEPTH = owm_pkg::QUEUE_DEPTH;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CNTW-1:0] FULL = CNTW'(DEPTH);

    owm_pkg::tick_item_t entry_reg [DEPTH];
    logic [AW-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [CNTW-1:0]     count_reg;

    assign q_status.push_ready = (count_reg != FULL);
    assign q_status.pop_valid = (count_reg != '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNTW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNTW'(1);
            end
        end
    end

    // The intake never pushes into a full queue, the sequencer never pops empty.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != FULL || pop)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue pop while empty");

endmodule

### hw/rtl/owm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_back: bus sequencer
// Runs one tick of the reset, write and read slot sequences per queued item
// and registers the per-tick result for the output channel.
// ----------------------------------------------------------------------------
module owm_back #(
    parameter int TICK_COUNTER_BITS = owm_pkg::TICK_COUNTER_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  owm_pkg::timing_cfg_t   timing,
    input  owm_pkg::queue_status_t q_status,
    input  owm_pkg::tick_item_t    item,
    output logic                   pop,
    owm_chan_if.source             out_ch
);

    localparam int CW = TICK_COUNTER_BITS;
    localparam int DW = (CW > 10) ? CW : 10;
    localparam logic [CW-1:0] TICK_MAX = '1;

    owm_pkg::phase_t  phase_reg, phase_next, ph_s;
    logic [CW-1:0]    tick_reg, tick_next, cnt_s, tick_base, tick_inc;
    logic [2:0]       bit_reg, bit_next, bit_s;
    logic [7:0]       shift_reg, shift_next, shift_s;
    owm_pkg::status_t status_reg, status_next;
    logic [7:0]       hold_reg, hold_next;
    logic [DW-1:0]    dur;
    logic             expired;
    logic             line;
    logic             drive;
    logic             done;
    logic             out_valid_reg;
    owm_pkg::out_item_t out_reg;

    assign line = item.line_level;
    assign pop = q_status.pop_valid && (!out_valid_reg || out_ch.ready);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.payload = out_reg;

    // A command from idle starts its first phase on the same tick.
    always_comb
    begin
        ph_s = phase_reg;
        cnt_s = tick_reg;
        bit_s = bit_reg;
        shift_s = shift_reg;
        if (phase_reg == owm_pkg::PH_IDLE && item.kind != owm_pkg::CMD_NONE)
        begin
            bit_s = '0;
            cnt_s = '0;
            unique case (item.kind)
                owm_pkg::CMD_RESET: ph_s = owm_pkg::PH_RST_LOW;
                owm_pkg::CMD_WRITE:
                begin
                    ph_s = owm_pkg::PH_WR_LOW;
                    shift_s = item.write_data;
                end
                owm_pkg::CMD_READ:
                begin
                    ph_s = owm_pkg::PH_RD_LOW;
                    shift_s = '0;
                end
                default: ph_s = phase_reg;
            endcase
        end
    end

    // Length of the current timed phase and the saturating tick count.
    always_comb
    begin
        unique case (ph_s)
            owm_pkg::PH_RST_LOW:   dur = DW'(timing.rst_low);
            owm_pkg::PH_RST_REL:   dur = DW'(timing.rst_release);
            owm_pkg::PH_PRES_HIGH: dur = line ? DW'(timing.pres_wait) : DW'(timing.pres_low);
            owm_pkg::PH_PRES_LOW:  dur = DW'(timing.pres_low);
            owm_pkg::PH_WR_LOW:    dur = shift_s[0] ? DW'(timing.wr1_low) : DW'(timing.wr0_low);
            owm_pkg::PH_WR_REC:    dur = shift_s[0] ? DW'(owm_pkg::REC_AFTER_ONE)
                                                    : DW'(owm_pkg::REC_AFTER_ZERO);
            owm_pkg::PH_RD_LOW:    dur = DW'(timing.rd_low);
            owm_pkg::PH_RD_TAIL:   dur = DW'(timing.rd_tail);
            default:               dur = '0;
        endcase
    end

    // The first low sample of a presence pulse counts from zero.
    assign tick_base = (ph_s == owm_pkg::PH_PRES_HIGH && !line) ? '0 : cnt_s;
    assign tick_inc = (tick_base != TICK_MAX) ? tick_base + CW'(1) : tick_base;
    assign expired = (DW'(tick_inc) >= dur) || (tick_inc == TICK_MAX);

    always_comb
    begin
        phase_next = ph_s;
        tick_next = cnt_s;
        bit_next = bit_s;
        shift_next = shift_s;
        status_next = status_reg;
        hold_next = hold_reg;
        drive = 1'b0;
        done = 1'b0;
        unique case (ph_s)
            owm_pkg::PH_RST_LOW:
            begin
                drive = 1'b1;
                tick_next = tick_inc;
                if (expired)
                begin
                    phase_next = (timing.rst_release == '0) ? owm_pkg::PH_PRES_HIGH
                                                            : owm_pkg::PH_RST_REL;
                    tick_next = '0;
                end
            end
            owm_pkg::PH_RST_REL:
            begin
                tick_next = tick_inc;
                if (expired)
                begin
                    phase_next = owm_pkg::PH_PRES_HIGH;
                    tick_next = '0;
                end
            end
            owm_pkg::PH_PRES_HIGH:
            begin
                tick_next = tick_inc;
                if (!line)
                begin
                    phase_next = owm_pkg::PH_PRES_LOW;
                end
                if (expired)
                begin
                    status_next = line ? owm_pkg::ST_NO_PRESENCE : owm_pkg::ST_PULSE_LONG;
                    phase_next = owm_pkg::PH_IDLE;
                    tick_next = '0;
                    done = 1'b1;
                end
            end
            owm_pkg::PH_PRES_LOW:
            begin
                if (line)
                begin
                    status_next = owm_pkg::ST_OK;
                    phase_next = owm_pkg::PH_IDLE;
                    tick_next = '0;
                    done = 1'b1;
                end
                else
                begin
                    tick_next = tick_inc;
                    if (expired)
                    begin
                        status_next = owm_pkg::ST_PULSE_LONG;
                        phase_next = owm_pkg::PH_IDLE;
                        tick_next = '0;
                        done = 1'b1;
                    end
                end
            end
            owm_pkg::PH_WR_LOW:
            begin
                drive = 1'b1;
                tick_next = tick_inc;
                if (expired)
                begin
                    phase_next = owm_pkg::PH_WR_REC;
                    tick_next = '0;
                end
            end
            owm_pkg::PH_WR_REC:
            begin
                tick_next = tick_inc;
                if (expired)
                begin
                    tick_next = '0;
                    if (bit_s == 3'd7)
                    begin
                        phase_next = owm_pkg::PH_IDLE;
                        done = 1'b1;
                    end
                    else
                    begin
                        shift_next = {1'b0, shift_s[7:1]};
                        bit_next = bit_s + 3'd1;
                        phase_next = owm_pkg::PH_WR_LOW;
                    end
                end
            end
            owm_pkg::PH_RD_LOW:
            begin
                drive = 1'b1;
                tick_next = tick_inc;
                if (expired)
                begin
                    phase_next = owm_pkg::PH_RD_SAMPLE;
                    tick_next = '0;
                end
            end
            owm_pkg::PH_RD_SAMPLE, owm_pkg::PH_RD_TAIL:
            begin
                if (ph_s == owm_pkg::PH_RD_SAMPLE)
                begin
                    shift_next = {line, shift_s[7:1]};
                    tick_next = '0;
                end
                else
                begin
                    tick_next = tick_inc;
                end
                // The bit ends on the sample tick when there is no tail wait.
                if ((ph_s == owm_pkg::PH_RD_SAMPLE && timing.rd_tail == '0)
                    || (ph_s == owm_pkg::PH_RD_TAIL && expired))
                begin
                    tick_next = '0;
                    if (bit_s == 3'd7)
                    begin
                        hold_next = shift_next;
                        phase_next = owm_pkg::PH_IDLE;
                        done = 1'b1;
                    end
                    else
                    begin
                        bit_next = bit_s + 3'd1;
                        phase_next = owm_pkg::PH_RD_LOW;
                    end
                end
                else if (ph_s == owm_pkg::PH_RD_SAMPLE)
                begin
                    phase_next = owm_pkg::PH_RD_TAIL;
                end
            end
            owm_pkg::PH_IDLE:
            begin
            end
            default:
            begin
                phase_next = owm_pkg::PH_IDLE;
                tick_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= owm_pkg::PH_IDLE;
            tick_reg <= '0;
            bit_reg <= '0;
            shift_reg <= '0;
            status_reg <= owm_pkg::ST_OK;
            hold_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg <= phase_next;
                tick_reg <= tick_next;
                bit_reg <= bit_next;
                shift_reg <= shift_next;
                status_reg <= status_next;
                hold_reg <= hold_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg.drive_low <= drive;
            out_reg.busy_res <= (phase_next != owm_pkg::PH_IDLE);
            out_reg.done_res <= done;
            out_reg.status <= status_next;
            out_reg.read_data <= hold_next;
        end
    end

    // Idle always comes with a cleared tick counter.
    a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == owm_pkg::PH_IDLE |-> tick_reg == '0)
        else $error("tick counter not cleared in idle");

    // A finishing tick leaves the sequencer idle and reports not busy.
    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop && done |=> phase_reg == owm_pkg::PH_IDLE && !out_reg.busy_res)
        else $error("command finished but sequencer not idle");

    // A command taken from idle starts at bit zero.
    a_start_bit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pop && phase_reg == owm_pkg::PH_IDLE && item.kind != owm_pkg::CMD_NONE
        |=> bit_reg == '0 || phase_reg == owm_pkg::PH_IDLE)
        else $error("bit index not cleared at command start");

    // Status changes only on a tick that ends a reset command.
    a_status_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(status_reg) |-> $past(pop && done))
        else $error("status changed outside a finishing tick");

endmodule

### hw/rtl/one_wire_bus_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_bus_master: 1-Wire bus master
// Top level: tick intake, queue, bus sequencer and timing registers.
// ----------------------------------------------------------------------------
// Each transfer on in_ch is one bus tick (normally one microsecond) and gives
// exactly one transfer on out_ch carrying the drive level and status of that
// tick. The block takes one tick every clock and produces one result every
// clock while out_ch is ready; back-pressure stalls both. A result passes
// through the two-entry queue and the output register before it is offered.
// The sequencer advances its state once per tick, so bus timing is counted
// in ticks, not in clocks. The user must write the timing registers through
// cfg_ch only while no command is running; the block does not enforce it.
module one_wire_bus_master #(
    parameter int TICK_COUNTER_BITS = owm_pkg::TICK_COUNTER_BITS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    owm_chan_if.sink   in_ch,
    owm_chan_if.source out_ch,
    owm_chan_if.sink   cfg_ch
);

    owm_pkg::timing_cfg_t   timing;
    owm_pkg::queue_status_t q_status;
    owm_pkg::tick_item_t    push_item;
    owm_pkg::tick_item_t    pop_item;
    logic                   push;
    logic                   pop;

    owm_cfg u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .timing (timing)
    );

    owm_front u_front (
        .in_ch     (in_ch),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    owm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_status  (q_status)
    );

    owm_back #(
        .TICK_COUNTER_BITS (TICK_COUNTER_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .timing   (timing),
        .q_status (q_status),
        .item     (pop_item),
        .pop      (pop),
        .out_ch   (out_ch)
    );

endmodule

### tb/tb_one_wire_bus_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_one_wire_bus_master: self-checking testbench of the 1-Wire bus master
// Sends a stream of bus ticks and acts as a simple bus device that answers
// presence and read slots. Every tick is run through a local bus sequencer
// model, and each result transfer is compared field by field with the
// predicted one. The run covers the reset timing, the minimum and maximum
// timing, presence corner cases, commands while busy, backpressure and
// random command streams.
// ----------------------------------------------------------------------------
module tb_one_wire_bus_master;

    localparam int unsigned TICK_LIMIT = (1 << owm_pkg::TICK_COUNTER_BITS_DEF) - 1;
    localparam int REG_WIDTH [8] = '{10, 8, 8, 8, 6, 7, 6, 7};
    localparam int HOLD_CYCLES = 80;
    localparam int RANDOM_SEGMENT_TICKS = 40;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;
    typedef enum int {DEV_PRESENT, DEV_ABSENT, DEV_STUCK_LOW} device_kind_t;

    logic clk;
    logic rst_n;

    owm_chan_if #(.payload_t(owm_pkg::in_item_t))  in_if ();
    owm_chan_if #(.payload_t(owm_pkg::out_item_t)) out_if ();
    owm_chan_if #(.payload_t(owm_pkg::cfg_wr_t))   cfg_if ();

    one_wire_bus_master i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if),
        .out_ch (out_if),
        .cfg_ch (cfg_if)
    );

    // Local copy of the timing registers and the sequencer state.
    int unsigned timing [8] = '{owm_pkg::RST_LOW_RESET, owm_pkg::RST_RELEASE_RESET,
                               owm_pkg::PRES_WAIT_RESET, owm_pkg::PRES_LOW_RESET,
                               owm_pkg::WR1_LOW_RESET, owm_pkg::WR0_LOW_RESET,
                               owm_pkg::RD_LOW_RESET, owm_pkg::RD_TAIL_RESET};
    owm_pkg::phase_t bus_phase = owm_pkg::PH_IDLE;
    int unsigned tick_cnt    = 0;
    logic [2:0]  bit_idx     = '0;
    logic [7:0]  shift_reg   = '0;
    logic [1:0]  status_hold = owm_pkg::ST_OK;
    logic [7:0]  read_byte   = '0;
    logic        done_pulse  = 1'b0;

    owm_pkg::out_item_t bus_result_q [$];

    // Bus device behavior during the presence check.
    int unsigned dev_hi     = 0;
    int unsigned dev_lo     = 0;
    int unsigned pres_ticks = 0;

    int unsigned ticks_sent = 0;
    int unsigned burst_left = 0;
    bit          tx_bursty  = 1'b1;
    rx_mode_t    rx_mode    = RX_OPEN;
    bit          hold_req   = 1'b0;
    int unsigned rx_cycle   = 0;
    int unsigned fail_cnt   = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequencer model
    // ------------------------------------------------------------------------
    function automatic void enter_phase(owm_pkg::phase_t p);
        bus_phase = p;
        tick_cnt = 0;
    endfunction

    // The counter saturates, and reaching saturation also ends the phase.
    function automatic bit count_tick(int unsigned dur);
        if (tick_cnt < TICK_LIMIT)
            tick_cnt++;
        return (tick_cnt >= dur) || (tick_cnt == TICK_LIMIT);
    endfunction

    function automatic void end_command();
        enter_phase(owm_pkg::PH_IDLE);
        done_pulse = 1'b1;
    endfunction

    function automatic void end_read_bit();
        if (bit_idx == 3'd7)
        begin
            read_byte = shift_reg;
            end_command();
        end
        else
        begin
            bit_idx++;
            enter_phase(owm_pkg::PH_RD_LOW);
        end
    endfunction

    function automatic owm_pkg::out_item_t predict_tick(owm_pkg::in_item_t it);
        owm_pkg::out_item_t res;
        logic drive;
        owm_pkg::cmd_kind_t cmd;
        drive = 1'b0;
        cmd = owm_pkg::cmd_kind_t'(it.command);
        done_pulse = 1'b0;
        if (bus_phase == owm_pkg::PH_IDLE && cmd != owm_pkg::CMD_NONE)
        begin
            bit_idx = '0;
            if (cmd == owm_pkg::CMD_RESET)
                enter_phase(owm_pkg::PH_RST_LOW);
            else if (cmd == owm_pkg::CMD_WRITE)
            begin
                shift_reg = it.write_data;
                enter_phase(owm_pkg::PH_WR_LOW);
            end
            else
            begin
                shift_reg = '0;
                enter_phase(owm_pkg::PH_RD_LOW);
            end
        end

        unique case (bus_phase)
            owm_pkg::PH_RST_LOW:
            begin
                drive = 1'b1;
                if (count_tick(timing[owm_pkg::CFG_RST_LOW]))
                    enter_phase(timing[owm_pkg::CFG_RST_RELEASE] == 0 ? owm_pkg::PH_PRES_HIGH
                                                                      : owm_pkg::PH_RST_REL);
            end
            owm_pkg::PH_RST_REL:
            begin
                if (count_tick(timing[owm_pkg::CFG_RST_RELEASE]))
                    enter_phase(owm_pkg::PH_PRES_HIGH);
            end
            owm_pkg::PH_PRES_HIGH:
            begin
                if (it.line_level)
                begin
                    if (count_tick(timing[owm_pkg::CFG_PRES_WAIT]))
                    begin
                        status_hold = owm_pkg::ST_NO_PRESENCE;
                        end_command();
                    end
                end
                else
                begin
                    // The first low sample already counts toward the pulse length.
                    enter_phase(owm_pkg::PH_PRES_LOW);
                    if (count_tick(timing[owm_pkg::CFG_PRES_LOW]))
                    begin
                        status_hold = owm_pkg::ST_PULSE_LONG;
                        end_command();
                    end
                end
            end
            owm_pkg::PH_PRES_LOW:
            begin
                if (it.line_level)
                begin
                    status_hold = owm_pkg::ST_OK;
                    end_command();
                end
                else if (count_tick(timing[owm_pkg::CFG_PRES_LOW]))
                begin
                    status_hold = owm_pkg::ST_PULSE_LONG;
                    end_command();
                end
            end
            owm_pkg::PH_WR_LOW:
            begin
                drive = 1'b1;
                if (count_tick(shift_reg[0] ? timing[owm_pkg::CFG_WR1_LOW]
                                            : timing[owm_pkg::CFG_WR0_LOW]))
                    enter_phase(owm_pkg::PH_WR_REC);
            end
            owm_pkg::PH_WR_REC:
            begin
                if (count_tick(shift_reg[0] ? owm_pkg::REC_AFTER_ONE : owm_pkg::REC_AFTER_ZERO))
                begin
                    if (bit_idx == 3'd7)
                        end_command();
                    else
                    begin
                        shift_reg = shift_reg >> 1;
                        bit_idx++;
                        enter_phase(owm_pkg::PH_WR_LOW);
                    end
                end
            end
            owm_pkg::PH_RD_LOW:
            begin
                drive = 1'b1;
                if (count_tick(timing[owm_pkg::CFG_RD_LOW]))
                    enter_phase(owm_pkg::PH_RD_SAMPLE);
            end
            owm_pkg::PH_RD_SAMPLE:
            begin
                shift_reg = {it.line_level, shift_reg[7:1]};
                if (timing[owm_pkg::CFG_RD_TAIL] == 0)
                    end_read_bit();
                else
                    enter_phase(owm_pkg::PH_RD_TAIL);
            end
            owm_pkg::PH_RD_TAIL:
            begin
                if (count_tick(timing[owm_pkg::CFG_RD_TAIL]))
                    end_read_bit();
            end
            owm_pkg::PH_IDLE: ;
            default: enter_phase(owm_pkg::PH_IDLE);
        endcase

        res.drive_low = drive;
        res.busy_res  = (bus_phase != owm_pkg::PH_IDLE);
        res.done_res  = done_pulse;
        res.status    = status_hold;
        res.read_data = read_byte;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Bus device and stimulus
    // ------------------------------------------------------------------------
    // The device pulls the line low after dev_hi presence ticks for dev_lo
    // ticks. Outside the presence check the level is random.
    function automatic logic bus_line_level();
        logic lvl;
        if (bus_phase == owm_pkg::PH_PRES_HIGH || bus_phase == owm_pkg::PH_PRES_LOW)
        begin
            lvl = (pres_ticks < dev_hi) || (pres_ticks >= dev_hi + dev_lo);
            pres_ticks++;
        end
        else
            lvl = 1'($urandom);
        return lvl;
    endfunction

    function automatic void pick_device(device_kind_t kind);
        int unsigned wait_max;
        int unsigned low_max;
        wait_max = (timing[owm_pkg::CFG_PRES_WAIT] > 1) ? timing[owm_pkg::CFG_PRES_WAIT] - 1 : 0;
        low_max  = (timing[owm_pkg::CFG_PRES_LOW] > 1) ? timing[owm_pkg::CFG_PRES_LOW] - 1 : 1;
        unique case (kind)
            DEV_PRESENT:
            begin
                dev_hi = $urandom_range(0, wait_max);
                dev_lo = $urandom_range(1, low_max);
            end
            DEV_ABSENT:
            begin
                dev_hi = 4096;
                dev_lo = 0;
            end
            default:
            begin
                dev_hi = $urandom_range(0, wait_max);
                dev_lo = 4096;
            end
        endcase
    endfunction

    // Offers one tick; valid stays high into the next tick unless a gap is due.
    task automatic send_tick(owm_pkg::cmd_kind_t cmd, logic [7:0] wd);
        owm_pkg::in_item_t it;
        it.command    = cmd;
        it.write_data = wd;
        it.line_level = bus_line_level();
        in_if.payload <= it;
        in_if.valid   <= 1'b1;
        do
            @(posedge clk);
        while (in_if.ready !== 1'b1);
        bus_result_q.push_back(predict_tick(it));
        ticks_sent++;
        if (tx_bursty)
        begin
            if (burst_left == 0)
            begin
                in_if.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
            else
                burst_left--;
        end
    endtask

    task automatic idle_ticks(int unsigned n);
        repeat (n) send_tick(owm_pkg::CMD_NONE, 8'($urandom));
    endtask

    // Starts a command and keeps ticking until the model is idle again.
    // With noisy set, ticks during the command carry random commands.
    task automatic run_command(owm_pkg::cmd_kind_t cmd, logic [7:0] wd, bit noisy);
        pres_ticks = 0;
        send_tick(cmd, wd);
        while (bus_phase != owm_pkg::PH_IDLE)
            send_tick(noisy ? owm_pkg::cmd_kind_t'($urandom_range(0, 3)) : owm_pkg::CMD_NONE,
                      8'($urandom));
    endtask

    task automatic run_reset(int unsigned hi, int unsigned lo);
        dev_hi = hi;
        dev_lo = lo;
        run_command(owm_pkg::CMD_RESET, 8'($urandom), 1'b0);
    endtask

    // Stops offering ticks and waits until every expected result has arrived.
    task automatic settle_bus();
        in_if.valid <= 1'b0;
        while (bus_result_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(owm_pkg::cfg_index_t idx, int unsigned val);
        owm_pkg::cfg_wr_t wr;
        wr.index = idx;
        wr.data  = val[owm_pkg::CFG_DATA_BITS-1:0];
        cfg_if.payload <= wr;
        cfg_if.valid   <= 1'b1;
        do
            @(posedge clk);
        while (cfg_if.ready !== 1'b1);
        timing[idx] = val & ((1 << REG_WIDTH[idx]) - 1);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_timing(int unsigned rst_low, int unsigned rst_rel,
                              int unsigned pres_wait, int unsigned pres_low,
                              int unsigned wr1_low, int unsigned wr0_low,
                              int unsigned rd_low, int unsigned rd_tail);
        settle_bus();
        write_reg(owm_pkg::CFG_RST_LOW, rst_low);
        write_reg(owm_pkg::CFG_RST_RELEASE, rst_rel);
        write_reg(owm_pkg::CFG_PRES_WAIT, pres_wait);
        write_reg(owm_pkg::CFG_PRES_LOW, pres_low);
        write_reg(owm_pkg::CFG_WR1_LOW, wr1_low);
        write_reg(owm_pkg::CFG_WR0_LOW, wr0_low);
        write_reg(owm_pkg::CFG_RD_LOW, rd_low);
        write_reg(owm_pkg::CFG_RD_TAIL, rd_tail);
    endtask

    task automatic set_random_short_timing();
        set_timing($urandom_range(1, 40), $urandom_range(0, 10), $urandom_range(1, 20),
                   $urandom_range(1, 20), $urandom_range(1, 10), $urandom_range(1, 15),
                   $urandom_range(1, 8), $urandom_range(0, 10));
    endtask

    // ------------------------------------------------------------------------
    // Receiver and result checking
    // ------------------------------------------------------------------------
    initial
    begin
        out_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (hold_req)
            begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                unique case (rx_mode)
                    RX_OPEN:   out_if.ready <= 1'b1;
                    RX_RANDOM: out_if.ready <= ($urandom_range(0, 99) >= 30);
                    default:   out_if.ready <= ((rx_cycle % 7) < 5);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        owm_pkg::out_item_t got;
        owm_pkg::out_item_t want;
        if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1)
        begin
            got = out_if.payload;
            if (bus_result_q.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("unexpected result transfer: drive=%0b busy=%0b done=%0b %s%0d %s%02h",
                             got.drive_low, got.busy_res, got.done_res,
                             "status=", got.status, "read=", got.read_data);
            end
            else
            begin
                want = bus_result_q.pop_front();
                if (got.drive_low !== want.drive_low || got.busy_res !== want.busy_res ||
                    got.done_res !== want.done_res || got.status !== want.status ||
                    got.read_data !== want.read_data)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                    begin
                        $display("mismatch: expected drive=%0b busy=%0b done=%0b status=%0d read=%02h",
                                 want.drive_low, want.busy_res, want.done_res, want.status,
                                 want.read_data);
                        $display("          got      drive=%0b busy=%0b done=%0b status=%0d read=%02h",
                                 got.drive_low, got.busy_res, got.done_res, got.status,
                                 got.read_data);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Register values after reset, with a device that answers promptly.
    task automatic test_reset_timing();
        rx_mode = RX_RANDOM;
        run_reset(2, 3);
        idle_ticks(2);
    endtask

    // Shortest timing: zero release and zero read tail are skipped, and any
    // presence sample ends the check at once.
    task automatic test_minimum_timing();
        set_timing(1, 0, 1, 1, 1, 1, 1, 0);
        rx_mode = RX_PATTERN;
        run_reset(4096, 0);
        run_reset(0, 4096);
        run_command(owm_pkg::CMD_WRITE, 8'h00, 1'b0);
        run_command(owm_pkg::CMD_WRITE, 8'h01, 1'b0);
        run_command(owm_pkg::CMD_READ, 8'h00, 1'b0);
    endtask

    // Top register values apart from rst_low: the longest release wait before a prompt presence pulse.
    task automatic test_maximum_timing();
        set_timing(1, 255, 255, 255, 63, 127, 63, 127);
        rx_mode = RX_OPEN;
        run_reset(0, 1);
    endtask

    task automatic test_presence_limits();
        set_timing(3, 2, 5, 5, 2, 3, 2, 1);
        rx_mode = RX_RANDOM;
        run_reset(4, 4);
        run_reset(5, 0);
        run_reset(0, 5);
        run_reset(0, 1);
        run_reset(4, 5);
        run_reset(2, 3);
    endtask

    task automatic test_busy_commands();
        run_command(owm_pkg::CMD_RESET, 8'($urandom), 1'b1);
        run_command(owm_pkg::CMD_WRITE, 8'h02, 1'b1);
        run_command(owm_pkg::CMD_READ, 8'($urandom), 1'b1);
    endtask

    // The receiver holds off while ticks keep coming, so the block fills up.
    task automatic test_output_holdoff();
        tx_bursty = 1'b0;
        hold_req = 1'b1;
        run_command(owm_pkg::CMD_READ, 8'h00, 1'b0);
        run_command(owm_pkg::CMD_WRITE, 8'h00, 1'b0);
        tx_bursty = 1'b1;
    endtask

    task automatic test_pause_until_drained();
        pick_device(DEV_PRESENT);
        run_command(owm_pkg::CMD_RESET, 8'($urandom), 1'b0);
        settle_bus();
        run_command(owm_pkg::CMD_WRITE, 8'h00, 1'b0);
        settle_bus();
        idle_ticks(3);
    endtask

    task automatic test_random_traffic();
        int unsigned goal;
        int unsigned roll;
        for (int seg = 0; seg < 3; seg++)
        begin
            set_random_short_timing();
            rx_mode = rx_mode_t'(seg % 3);
            tx_bursty = (seg % 2 == 0);
            goal = ticks_sent + RANDOM_SEGMENT_TICKS;
            while (ticks_sent < goal)
            begin
                roll = $urandom_range(0, 9);
                pick_device(roll < 7 ? DEV_PRESENT : (roll < 9 ? DEV_STUCK_LOW : DEV_ABSENT));
                run_command(owm_pkg::cmd_kind_t'($urandom_range(1, 3)), 8'($urandom),
                            $urandom_range(0, 3) == 0);
                idle_ticks($urandom_range(0, 3));
            end
        end
    endtask

    initial
    begin
        in_if.valid    = 1'b0;
        in_if.payload  = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.payload = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_timing();
        test_minimum_timing();
        test_maximum_timing();
        test_presence_limits();
        test_busy_commands();
        test_output_holdoff();
        test_pause_until_drained();
        test_random_traffic();

        settle_bus();
        repeat (10) @(posedge clk);
        if (fail_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
